>>> hdl/plate_potential_gauss_quadrature_macros.svh
// assertion macros shared by the plate potential quadrature rtl
// expects clk and rst in the scope of the module that uses them
`ifndef PLATE_POTENTIAL_GAUSS_QUADRATURE_MACROS_SVH
`define PLATE_POTENTIAL_GAUSS_QUADRATURE_MACROS_SVH
`ifndef SYNTHESIS
`define PGQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pgq: assertion failed");
`define PGQ_NEVER(lbl, cond) \
  `PGQ_ASSERT(lbl, !(cond))
`else
`define PGQ_ASSERT(lbl, prop)
`define PGQ_NEVER(lbl, cond)
`endif
`endif

>>> hdl/pgq_pkg.sv
// types, widths and node/weight tables of the plate potential quadrature block
// no dependencies
`default_nettype none

package pgq_pkg;

  localparam int NodeCount     = 5;
  localparam int NodeIdxW      = $clog2(NodeCount);
  localparam int CoordFracBits = 8;
  localparam int CoordW        = 16;
  localparam int SpanW         = CoordW + 1;
  localparam int BaseW         = CoordW + 3;
  localparam int NodeW         = 17;
  localparam int DW            = 36;
  localparam int OffW          = 27;
  localparam int SqW           = 2 * OffW;
  localparam int R2W           = SqW + 1;
  localparam int QW            = 63;
  localparam int RootW         = 64;
  localparam int GW            = 32;
  localparam int PwW           = 15;
  localparam int TermW         = PwW + GW;
  localparam int AccW          = 52;
  localparam int AccHalfW      = AccW / 2;
  localparam int AreaW         = 2 * CoordW;
  localparam int PartW         = AccHalfW + AreaW;
  localparam int ProdW         = AccW + AreaW;
  localparam int PotW          = 24;
  localparam int ShiftBits     = 24 + CoordFracBits;
  localparam int SatBit        = ShiftBits + PotW;
  localparam int QueueDepth    = 4;
  localparam int AfDepth       = 8;

  localparam logic signed [CoordW-1:0] XLowReset  = 16'sd0;
  localparam logic signed [CoordW-1:0] XHighReset = 16'sd512;
  localparam logic signed [CoordW-1:0] YLowReset  = 16'sd0;
  localparam logic signed [CoordW-1:0] YHighReset = 16'sd256;

  typedef enum logic [1:0] {
    CFG_X_LOW  = 2'd0,
    CFG_X_HIGH = 2'd1,
    CFG_Y_LOW  = 2'd2,
    CFG_Y_HIGH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] obs_x;
    logic signed [CoordW-1:0] obs_y;
  } obs_t;

  typedef struct packed {
    logic [PotW-1:0] potential;
    logic            saturated;
  } pot_t;

  typedef logic [OffW-1:0] off_t;

  // one point after node mapping: node offset magnitudes and area
  typedef struct packed {
    off_t [NodeCount-1:0] dx;
    off_t [NodeCount-1:0] dy;
    logic [AreaW-1:0]     area;
  } job_t;

  // sideband carried with each node pair down the back pipeline
  typedef struct packed {
    logic           first;
    logic           last;
    logic           zero;
    logic [PwW-1:0] pw;
  } tag_t;

  // gauss-legendre nodes, signed q0.16
  function automatic logic signed [NodeW-1:0] node_q16(input int k);
    logic signed [NodeW-1:0] n;
    case (k)
      0:       n = 17'sd59387;
      1:       n = 17'sd35289;
      3:       n = -17'sd35289;
      4:       n = -17'sd59387;
      default: n = 17'sd0;
    endcase
    return n;
  endfunction

  // gauss-legendre weights, unsigned q0.16
  function automatic logic [15:0] weight_q16(input int k);
    logic [15:0] w;
    case (k)
      0, 4:    w = 16'd15527;
      1, 3:    w = 16'd31367;
      default: w = 16'd37283;
    endcase
    return w;
  endfunction

  function automatic logic [PwW-1:0] pair_weight(input int i, input int j);
    logic [31:0] p;
    p = 32'(weight_q16(i)) * 32'(weight_q16(j));
    return p[PwW+15:16];
  endfunction

endpackage

`default_nettype wire

>>> hdl/pgq_front.sv
// front end: configuration registers, point capture and node offset mapping
// depends on pgq_pkg
`default_nettype none

module pgq_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  pgq_pkg::cfg_reg_t   cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                obs_valid,
  output logic                obs_stall,
  input  pgq_pkg::obs_t       obs,
  output logic                job_push,
  output pgq_pkg::job_t       job,
  input  logic                q_full
);

  logic signed [pgq_pkg::CoordW-1:0] x_low, x_high, y_low, y_high;
  logic                              s1_valid;
  logic signed [pgq_pkg::SpanW-1:0]  span_x, span_y;
  logic signed [pgq_pkg::BaseW-1:0]  base_x, base_y;
  logic        [pgq_pkg::SpanW-1:0]  abs_x, abs_y;
  logic                              accept;

  // |span*node + base*2^16| in 2^-17 lsb, rounded half up to 2^-9 lsb
  function automatic pgq_pkg::off_t offset_mag(
    input logic signed [pgq_pkg::SpanW-1:0] span,
    input logic signed [pgq_pkg::BaseW-1:0] base,
    input int                               k
  );
    logic signed [2*pgq_pkg::SpanW-1:0] prod;
    logic signed [pgq_pkg::DW-1:0]      d;
    logic        [pgq_pkg::DW-1:0]      m;
    logic        [pgq_pkg::DW-1:0]      r;
    prod = span * pgq_pkg::node_q16(k);
    d    = pgq_pkg::DW'(prod) + (pgq_pkg::DW'(base) <<< 16);
    m    = d[pgq_pkg::DW-1] ? pgq_pkg::DW'(-d) : pgq_pkg::DW'(d);
    r    = m + pgq_pkg::DW'(128);
    return r[pgq_pkg::OffW+7:8];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      x_low  <= pgq_pkg::XLowReset;
      x_high <= pgq_pkg::XHighReset;
      y_low  <= pgq_pkg::YLowReset;
      y_high <= pgq_pkg::YHighReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pgq_pkg::CFG_X_LOW:  x_low  <= cfg_data;
        pgq_pkg::CFG_X_HIGH: x_high <= cfg_data;
        pgq_pkg::CFG_Y_LOW:  y_low  <= cfg_data;
        pgq_pkg::CFG_Y_HIGH: y_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign obs_stall = s1_valid && q_full;
  assign accept    = obs_valid && !obs_stall;
  assign job_push  = s1_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!obs_stall) begin
      s1_valid <= obs_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      span_x <= pgq_pkg::SpanW'(x_high) - pgq_pkg::SpanW'(x_low);
      span_y <= pgq_pkg::SpanW'(y_high) - pgq_pkg::SpanW'(y_low);
      base_x <= pgq_pkg::BaseW'(x_low) + pgq_pkg::BaseW'(x_high)
                - (pgq_pkg::BaseW'(obs.obs_x) <<< 1);
      base_y <= pgq_pkg::BaseW'(y_low) + pgq_pkg::BaseW'(y_high)
                - (pgq_pkg::BaseW'(obs.obs_y) <<< 1);
    end
  end

  // side lengths taken as magnitudes, reversed bounds give the same area
  always_comb begin
    abs_x = span_x[pgq_pkg::SpanW-1] ? pgq_pkg::SpanW'(-span_x) : pgq_pkg::SpanW'(span_x);
    abs_y = span_y[pgq_pkg::SpanW-1] ? pgq_pkg::SpanW'(-span_y) : pgq_pkg::SpanW'(span_y);
    job.area = pgq_pkg::AreaW'(abs_x[pgq_pkg::CoordW-1:0])
             * pgq_pkg::AreaW'(abs_y[pgq_pkg::CoordW-1:0]);
    for (int k = 0; k < pgq_pkg::NodeCount; k++) begin
      job.dx[k] = offset_mag(span_x, base_x, k);
      job.dy[k] = offset_mag(span_y, base_y, k);
    end
  end

endmodule

`default_nettype wire

>>> hdl/pgq_queue.sv
// short job queue between front and back, register array storage
// depends on pgq_pkg and the assertion macro header
`default_nettype none
`include "plate_potential_gauss_quadrature_macros.svh"

module pgq_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pgq_pkg::job_t din,
  input  logic          pop,
  output pgq_pkg::job_t dout,
  output logic          full,
  output logic          empty
);

  localparam int PtrW = $clog2(pgq_pkg::QueueDepth);

  pgq_pkg::job_t   mem [pgq_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [PtrW:0]   count;

  assign full  = count == (PtrW+1)'(pgq_pkg::QueueDepth);
  assign empty = count == '0;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  `PGQ_NEVER(a_queue_overrun, push && full)
  `PGQ_NEVER(a_queue_underrun, pop && empty)

endmodule

`default_nettype wire

>>> hdl/pgq_rsqrt.sv
// pipelined inverse distance: floor(2^62 / r2) one quotient bit per stage,
// then integer square root one result bit per stage; depends on pgq_pkg
`default_nettype none

module pgq_rsqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic [pgq_pkg::R2W-1:0]  in_r2,
  input  pgq_pkg::tag_t            in_tag,
  output logic                     out_valid,
  output logic [pgq_pkg::GW-1:0]   out_g,
  output pgq_pkg::tag_t            out_tag
);

  localparam int DivSteps = pgq_pkg::QW;
  localparam int SqSteps  = pgq_pkg::RootW / 2;

  // divider stages
  logic [DivSteps-1:0]        dv_valid;
  logic [pgq_pkg::R2W-1:0]    dv_rem   [DivSteps];
  logic [pgq_pkg::R2W-1:0]    dv_den   [DivSteps];
  logic [pgq_pkg::QW-1:0]     dv_q     [DivSteps];
  pgq_pkg::tag_t              dv_tag   [DivSteps];
  logic [pgq_pkg::R2W-1:0]    src_rem  [DivSteps];
  logic [pgq_pkg::R2W-1:0]    src_den  [DivSteps];
  logic [pgq_pkg::QW-1:0]     src_q    [DivSteps];
  logic [pgq_pkg::R2W:0]      trial    [DivSteps];
  logic [pgq_pkg::R2W-1:0]    rem_next [DivSteps];
  logic [pgq_pkg::QW-1:0]     q_next   [DivSteps];

  // square root stages
  logic [SqSteps-1:0]         sq_valid;
  logic [pgq_pkg::RootW-1:0]  sq_v     [SqSteps];
  logic [pgq_pkg::RootW-1:0]  sq_res   [SqSteps];
  pgq_pkg::tag_t              sq_tag   [SqSteps];
  logic [pgq_pkg::RootW-1:0]  src_v    [SqSteps];
  logic [pgq_pkg::RootW-1:0]  src_res  [SqSteps];
  logic [pgq_pkg::RootW-1:0]  sum      [SqSteps];
  logic [pgq_pkg::RootW-1:0]  v_next   [SqSteps];
  logic [pgq_pkg::RootW-1:0]  res_next [SqSteps];

  always_comb begin
    src_rem[0] = '0;
    src_den[0] = in_r2;
    src_q[0]   = '0;
    for (int s = 1; s < DivSteps; s++) begin
      src_rem[s] = dv_rem[s-1];
      src_den[s] = dv_den[s-1];
      src_q[s]   = dv_q[s-1];
    end
    // the dividend has only its top bit set, fed in at the first stage
    for (int s = 0; s < DivSteps; s++) begin
      trial[s] = {src_rem[s], 1'(s == 0)};
      if (trial[s] >= {1'b0, src_den[s]}) begin
        rem_next[s] = pgq_pkg::R2W'(trial[s] - {1'b0, src_den[s]});
        q_next[s]   = {src_q[s][pgq_pkg::QW-2:0], 1'b1};
      end else begin
        rem_next[s] = trial[s][pgq_pkg::R2W-1:0];
        q_next[s]   = {src_q[s][pgq_pkg::QW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    src_v[0]   = pgq_pkg::RootW'(dv_q[DivSteps-1]);
    src_res[0] = '0;
    for (int k = 1; k < SqSteps; k++) begin
      src_v[k]   = sq_v[k-1];
      src_res[k] = sq_res[k-1];
    end
    for (int k = 0; k < SqSteps; k++) begin
      sum[k] = src_res[k] + (pgq_pkg::RootW'(1) << (2 * (SqSteps - 1 - k)));
      if (src_v[k] >= sum[k]) begin
        v_next[k]   = src_v[k] - sum[k];
        res_next[k] = (src_res[k] >> 1) + (pgq_pkg::RootW'(1) << (2 * (SqSteps - 1 - k)));
      end else begin
        v_next[k]   = src_v[k];
        res_next[k] = src_res[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid <= '0;
      sq_valid <= '0;
    end else if (adv) begin
      dv_valid <= {dv_valid[DivSteps-2:0], in_valid};
      sq_valid <= {sq_valid[SqSteps-2:0], dv_valid[DivSteps-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_tag[0] <= in_tag;
      for (int s = 1; s < DivSteps; s++) dv_tag[s] <= dv_tag[s-1];
      for (int s = 0; s < DivSteps; s++) begin
        dv_rem[s] <= rem_next[s];
        dv_den[s] <= src_den[s];
        dv_q[s]   <= q_next[s];
      end
      sq_tag[0] <= dv_tag[DivSteps-1];
      for (int k = 1; k < SqSteps; k++) sq_tag[k] <= sq_tag[k-1];
      for (int k = 0; k < SqSteps; k++) begin
        sq_v[k]   <= v_next[k];
        sq_res[k] <= res_next[k];
      end
    end
  end

  assign out_valid = sq_valid[SqSteps-1];
  assign out_g     = sq_res[SqSteps-1][pgq_pkg::GW-1:0];
  assign out_tag   = sq_tag[SqSteps-1];

endmodule

`default_nettype wire

>>> hdl/pgq_back.sv
// back end: node pair sequencer, distance pipeline, accumulation,
// jacobian scaling and result register; depends on pgq_pkg, pgq_rsqrt
`default_nettype none
`include "plate_potential_gauss_quadrature_macros.svh"

module pgq_back (
  input  logic          clk,
  input  logic          rst,
  input  pgq_pkg::job_t job,
  input  logic          job_ready,
  output logic          job_pop,
  output logic          res_valid,
  input  logic          res_stall,
  output pgq_pkg::pot_t res
);

  localparam int AfPtrW = $clog2(pgq_pkg::AfDepth);
  localparam logic [pgq_pkg::NodeIdxW-1:0] LastIdx = pgq_pkg::NodeIdxW'(pgq_pkg::NodeCount - 1);

  logic                             adv, first_pair, last_pair, issue;
  logic [pgq_pkg::NodeIdxW-1:0]     cnt_i, cnt_j;

  logic                             a_valid, b_valid, c_valid, g_valid, t_valid, e_valid, f1_valid;
  pgq_pkg::off_t                    a_dx, a_dy;
  pgq_pkg::tag_t                    a_tag, b_tag, c_tag, g_tag, t_tag;
  logic [pgq_pkg::SqW-1:0]          sqx, sqy;
  logic [pgq_pkg::R2W-1:0]          c_r2;
  logic [pgq_pkg::GW-1:0]           g;
  logic [pgq_pkg::TermW-1:0]        t_term;
  logic [pgq_pkg::AccW-1:0]         acc;
  logic                             acc_zero;
  logic [pgq_pkg::PartW-1:0]        p0, p1;
  logic                             f1_zero;
  logic [pgq_pkg::ProdW-1:0]        prod;
  logic                             over;

  logic [pgq_pkg::AreaW-1:0]        af_mem [pgq_pkg::AfDepth];
  logic [AfPtrW-1:0]                af_wr, af_rd;
  logic [AfPtrW:0]                  af_count;
  logic                             af_push, af_pop, af_full;

  // whole pipeline holds while a result waits in the output register
  assign adv        = !res_valid || !res_stall;
  assign first_pair = (cnt_i == '0) && (cnt_j == '0);
  assign last_pair  = (cnt_i == LastIdx) && (cnt_j == LastIdx);
  assign af_full    = af_count == (AfPtrW+1)'(pgq_pkg::AfDepth);
  assign issue      = adv && job_ready && (!first_pair || !af_full);
  assign job_pop    = issue && last_pair;
  assign af_push    = issue && first_pair;
  assign af_pop     = adv && e_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_i <= '0;
      cnt_j <= '0;
    end else if (issue) begin
      if (cnt_j == LastIdx) begin
        cnt_j <= '0;
        cnt_i <= (cnt_i == LastIdx) ? '0 : cnt_i + 1'b1;
      end else begin
        cnt_j <= cnt_j + 1'b1;
      end
    end
  end

  // area of each point in flight, taken back when its sum completes
  always_ff @(posedge clk) begin
    if (rst) begin
      af_wr    <= '0;
      af_rd    <= '0;
      af_count <= '0;
    end else begin
      if (af_push) af_wr <= af_wr + 1'b1;
      if (af_pop)  af_rd <= af_rd + 1'b1;
      if (af_push && !af_pop)      af_count <= af_count + 1'b1;
      else if (af_pop && !af_push) af_count <= af_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (af_push) af_mem[af_wr] <= job.area;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      t_valid  <= 1'b0;
      e_valid  <= 1'b0;
      f1_valid <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      a_valid  <= issue;
      b_valid  <= a_valid;
      c_valid  <= b_valid;
      t_valid  <= g_valid;
      e_valid  <= t_valid && t_tag.last;
      f1_valid <= e_valid;
      res_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (issue) begin
        a_dx        <= job.dx[cnt_i];
        a_dy        <= job.dy[cnt_j];
        a_tag.first <= first_pair;
        a_tag.last  <= last_pair;
        a_tag.zero  <= 1'b0;
        a_tag.pw    <= pgq_pkg::pair_weight(int'(cnt_i), int'(cnt_j));
      end
      sqx   <= pgq_pkg::SqW'(a_dx) * pgq_pkg::SqW'(a_dx);
      sqy   <= pgq_pkg::SqW'(a_dy) * pgq_pkg::SqW'(a_dy);
      b_tag <= a_tag;
      c_r2  <= pgq_pkg::R2W'(sqx) + pgq_pkg::R2W'(sqy);
      c_tag <= '{first: b_tag.first, last: b_tag.last,
                 zero: (sqx == '0) && (sqy == '0), pw: b_tag.pw};
      t_term <= g_tag.zero ? '0 : pgq_pkg::TermW'(g_tag.pw) * pgq_pkg::TermW'(g);
      t_tag  <= g_tag;
      if (t_valid) begin
        acc      <= (t_tag.first ? '0 : acc) + pgq_pkg::AccW'(t_term);
        acc_zero <= (t_tag.first ? 1'b0 : acc_zero) | t_tag.zero;
      end
      if (e_valid) begin
        p0 <= pgq_pkg::PartW'(acc[pgq_pkg::AccHalfW-1:0]) * pgq_pkg::PartW'(af_mem[af_rd]);
        p1 <= pgq_pkg::PartW'(acc[pgq_pkg::AccW-1:pgq_pkg::AccHalfW])
              * pgq_pkg::PartW'(af_mem[af_rd]);
        f1_zero <= acc_zero;
      end
      if (f1_valid) begin
        res.saturated <= f1_zero || over;
        res.potential <= (f1_zero || over) ? '1
                         : prod[pgq_pkg::ShiftBits+pgq_pkg::PotW-1:pgq_pkg::ShiftBits];
      end
    end
  end

  always_comb begin
    prod = pgq_pkg::ProdW'(p0) + (pgq_pkg::ProdW'(p1) << pgq_pkg::AccHalfW);
    over = |prod[pgq_pkg::ProdW-1:pgq_pkg::SatBit];
  end

  pgq_rsqrt u_rsqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (c_valid),
    .in_r2     (c_r2),
    .in_tag    (c_tag),
    .out_valid (g_valid),
    .out_g     (g),
    .out_tag   (g_tag)
  );

  `PGQ_NEVER(a_area_overrun, af_push && af_full && !af_pop)
  `PGQ_ASSERT(a_sum_has_area, adv && e_valid |-> af_count != '0)

endmodule

`default_nettype wire

>>> hdl/plate_potential_gauss_quadrature.sv
// top level of the plate potential quadrature block
// depends on pgq_pkg, pgq_front, pgq_queue, pgq_back
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------
//  obs     | in        | obs_valid / obs_stall | pgq_pkg::obs_t  obs_x, obs_y (q8.8)
//  res     | out       | res_valid / res_stall | pgq_pkg::pot_t  potential, saturated
//  cfg     | in        | cfg_we                | cfg_index, cfg_data (16 bit)
//
// the back end sends one node pair a cycle, unless a result is stalled, no job is
// queued or the area store is full, through a single shared divide / square root
// pipeline, 25 node pairs per point; a point passes front capture and the queue,
// then each node pair goes through capture, squaring, 63 divider stages and
// 32 square root stages, then accumulation and scaling
// the front takes points at one a cycle until the four-entry job queue fills
// reset is synchronous and restores the default rectangle
// a stall on res freezes the back pipeline; the front and queue keep running
`default_nettype none

module plate_potential_gauss_quadrature (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  pgq_pkg::cfg_reg_t cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              obs_valid,
  output logic              obs_stall,
  input  pgq_pkg::obs_t     obs,
  output logic              res_valid,
  input  logic              res_stall,
  output pgq_pkg::pot_t     res
);

  // front to queue
  logic          job_push;
  pgq_pkg::job_t job_in;
  logic          q_full;

  // queue to back
  pgq_pkg::job_t job_head;
  logic          q_empty;
  logic          job_pop;

  // front: holds the bounds, maps the five nodes of each axis relative to the observer
  pgq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .obs_valid (obs_valid),
    .obs_stall (obs_stall),
    .obs       (obs),
    .job_push  (job_push),
    .job       (job_in),
    .q_full    (q_full)
  );

  // decouples the front, one point a cycle while the queue has room, from the back end
  pgq_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_in),
    .pop   (job_pop),
    .dout  (job_head),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: 25 node pairs per point, inverse distance, weighted sum, jacobian
  pgq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_head),
    .job_ready (!q_empty),
    .job_pop   (job_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

`default_nettype wire

>>> test/plate_potential_gauss_quadrature_checker.sv
// checker for the plate potential quadrature block: tracks register writes,
// predicts each result from accepted points and compares; depends on pgq_pkg
`default_nettype none

module plate_potential_gauss_quadrature_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  pgq_pkg::cfg_reg_t cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              obs_valid,
  input  logic              obs_stall,
  input  pgq_pkg::obs_t     obs,
  input  logic              res_valid,
  input  logic              res_stall,
  input  pgq_pkg::pot_t     res,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint GaussNode[5] = '{59387, 35289, 0, -35289, -59387};
  localparam longint unsigned GaussWeight[5] = '{15527, 31367, 37283, 31367, 15527};

  logic signed [15:0] rect_x_lo, rect_x_hi, rect_y_lo, rect_y_hi;
  pgq_pkg::pot_t      expected_pots[$];

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // rounded magnitude of each mapped node minus the observer, 2^-9 lsb units
  function automatic void node_offsets(input longint lo, input longint hi, input longint o,
                                       output longint unsigned mag[5]);
    longint d;
    for (int k = 0; k < 5; k++) begin
      d = (hi - lo) * GaussNode[k] + (lo + hi - 2 * o) * 65536;
      mag[k] = ((d < 0 ? -d : d) + 128) >> 8;
    end
  endfunction

  function automatic pgq_pkg::pot_t potential_of(input pgq_pkg::obs_t p);
    longint unsigned dxm[5], dym[5];
    longint unsigned r2, acc, area;
    longint          wx, wy;
    logic [127:0]    prod;
    logic            sat;
    pgq_pkg::pot_t   r;
    acc = 0;
    sat = 1'b0;
    node_offsets(rect_x_lo, rect_x_hi, p.obs_x, dxm);
    node_offsets(rect_y_lo, rect_y_hi, p.obs_y, dym);
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++) begin
        r2 = dxm[i] * dxm[i] + dym[j] * dym[j];
        if (r2 == 0) sat = 1'b1;
        else acc += ((GaussWeight[i] * GaussWeight[j]) >> 16) *
                    int_sqrt(64'h4000_0000_0000_0000 / r2);
      end
    wx = longint'(rect_x_hi) - longint'(rect_x_lo);
    wy = longint'(rect_y_hi) - longint'(rect_y_lo);
    area = longint'(wx < 0 ? -wx : wx) * longint'(wy < 0 ? -wy : wy);
    prod = 128'(acc) * 128'(area);
    if (prod[127:56] != 0) sat = 1'b1;
    r.saturated = sat;
    r.potential = sat ? 24'hFFFFFF : prod[55:32];
    return r;
  endfunction

  always @(posedge clk) begin
    pgq_pkg::pot_t want;
    if (rst) begin
      rect_x_lo = pgq_pkg::XLowReset;
      rect_x_hi = pgq_pkg::XHighReset;
      rect_y_lo = pgq_pkg::YLowReset;
      rect_y_hi = pgq_pkg::YHighReset;
      expected_pots.delete();
      errors = 0;
    end else begin
      if (cfg_we)
        case (cfg_index)
          pgq_pkg::CFG_X_LOW:  rect_x_lo = cfg_data;
          pgq_pkg::CFG_X_HIGH: rect_x_hi = cfg_data;
          pgq_pkg::CFG_Y_LOW:  rect_y_lo = cfg_data;
          pgq_pkg::CFG_Y_HIGH: rect_y_hi = cfg_data;
          default: ;
        endcase
      if (obs_valid && !obs_stall) expected_pots.push_back(potential_of(obs));
      if (res_valid && !res_stall) begin
        if (expected_pots.size() == 0) begin
          $error("unexpected transaction: potential %0h saturated %0b",
                 res.potential, res.saturated);
          errors++;
        end else begin
          want = expected_pots.pop_front();
          if (res.potential !== want.potential) begin
            $error("potential: expected %0h actual %0h", want.potential, res.potential);
            errors++;
          end
          if (res.saturated !== want.saturated) begin
            $error("saturated: expected %0b actual %0b", want.saturated, res.saturated);
            errors++;
          end
        end
      end
    end
    pending = expected_pots.size();
  end

endmodule

`default_nettype wire

>>> test/plate_potential_gauss_quadrature_tb.sv
// top of the plate potential quadrature testbench: clock, reset, register phases,
// point stimulus and verdict; depends on pgq_pkg, the block and its checker
`default_nettype none

module plate_potential_gauss_quadrature_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int DrainGap   = 160;   // margin for the pipeline tail after the checker has emptied

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  pgq_pkg::cfg_reg_t cfg_index = pgq_pkg::CFG_X_LOW;
  logic [15:0]       cfg_data = '0;
  logic              obs_valid = 1'b0;
  logic              obs_stall;
  pgq_pkg::obs_t     obs = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  pgq_pkg::pot_t     res;
  int                errors, pending;
  int                cycle = 0;
  logic              calm;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  plate_potential_gauss_quadrature u_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .obs_valid, .obs_stall, .obs, .res_valid, .res_stall, .res
  );

  plate_potential_gauss_quadrature_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .obs_valid, .obs_stall, .obs, .res_valid, .res_stall, .res,
    .errors, .pending
  );

  // a long stretch with no idling on either side
  assign calm = (cycle >= 4000) && (cycle < 10000);

  // cycle counter doubles as the watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // outside the calm stretch the receiver stalls at random, 23 times in a hundred
  always @(posedge clk)
    res_stall <= !rst && !calm && ($urandom_range(99) < 23);

  // current rectangle, kept here for shaping the stimulus
  logic signed [15:0] x_lo_now = pgq_pkg::XLowReset, x_hi_now = pgq_pkg::XHighReset;
  logic signed [15:0] y_lo_now = pgq_pkg::YLowReset, y_hi_now = pgq_pkg::YHighReset;

  // one point transaction; returns in the time step of its acceptance
  task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py);
    while (!calm && $urandom_range(99) < 23) begin
      obs_valid <= 1'b0;
      @(posedge clk);
    end
    obs_valid <= 1'b1;
    obs       <= '{obs_x: px, obs_y: py};
    @(posedge clk);
    while (obs_stall) @(posedge clk);
  endtask

  // let every result come back, then the tail of the pipeline settle
  task automatic drain();
    obs_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainGap) @(posedge clk);
  endtask

  task automatic write_reg(input pgq_pkg::cfg_reg_t idx, input logic [15:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
  endtask

  task automatic set_rect(input logic signed [15:0] xl, input logic signed [15:0] xh,
                          input logic signed [15:0] yl, input logic signed [15:0] yh);
    drain();
    write_reg(pgq_pkg::CFG_X_LOW, xl);
    write_reg(pgq_pkg::CFG_X_HIGH, xh);
    write_reg(pgq_pkg::CFG_Y_LOW, yl);
    write_reg(pgq_pkg::CFG_Y_HIGH, yh);
    @(posedge clk);
    cfg_we <= 1'b0;
    x_lo_now = xl; x_hi_now = xh; y_lo_now = yl; y_hi_now = yh;
    @(posedge clk);
  endtask

  // uniform pick between two bounds in either order
  function automatic logic signed [15:0] between(input int a, input int b);
    int lo, hi;
    lo = a < b ? a : b;
    hi = a < b ? b : a;
    return 16'(lo + int'($urandom_range(hi - lo)));
  endfunction

  // mostly points in and around the rectangle, some at its centre
  // (zero distance when the centre is exact), some anywhere
  task automatic random_points(input int count);
    int sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 45)
        send_point(between(x_lo_now, x_hi_now), between(y_lo_now, y_hi_now));
      else if (sel < 60)
        send_point(16'((int'(x_lo_now) + int'(x_hi_now)) >>> 1),
                   16'((int'(y_lo_now) + int'(y_hi_now)) >>> 1));
      else if (sel < 72)
        send_point($urandom_range(1) ? x_lo_now : x_hi_now,
                   $urandom_range(1) ? y_lo_now : y_hi_now);
      else
        send_point(16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed points on the reset rectangle: centre gives zero distance,
    // corners, edges and the coordinate extremes
    send_point(16'sd256, 16'sd128);
    send_point(16'sd0, 16'sd0);
    send_point(16'sd512, 16'sd256);
    send_point(16'sd256, 16'sd0);
    send_point(-16'sd32768, -16'sd32768);
    send_point(16'sd32767, 16'sd32767);
    send_point(-16'sd32768, 16'sd32767);
    send_point(16'sd32767, -16'sd32768);
    send_point(16'sd0, 16'sd1000);
    send_point(-16'sd1, -16'sd1);
    random_points(60);

    // widest rectangle: overflow near the plate
    set_rect(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
    send_point(16'sd0, 16'sd0);
    send_point(-16'sd32768, 16'sd32767);
    random_points(70);

    // reversed bounds, same plate as after reset
    set_rect(16'sd512, 16'sd0, 16'sd256, 16'sd0);
    send_point(16'sd256, 16'sd128);
    random_points(70);

    // zero width: potential zero unless a node lands on the observer
    set_rect(16'sd100, 16'sd100, -16'sd50, 16'sd300);
    send_point(16'sd100, 16'sd125);
    random_points(60);

    // tiny plate
    set_rect(-16'sd4, 16'sd4, -16'sd2, 16'sd2);
    random_points(70);

    // upper extreme below lower extreme, unit height
    set_rect(16'sd32767, -16'sd32768, 16'sd0, 16'sd1);
    random_points(60);

    // random rectangles
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 0)
        set_rect(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else
        set_rect(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                 16'($urandom_range(4095)), 16'($urandom_range(4095)));
      random_points(70);
    end

    drain();
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+hdl
hdl/pgq_pkg.sv
hdl/pgq_front.sv
hdl/pgq_queue.sv
hdl/pgq_rsqrt.sv
hdl/pgq_back.sv
hdl/plate_potential_gauss_quadrature.sv
test/plate_potential_gauss_quadrature_checker.sv
test/plate_potential_gauss_quadrature_tb.sv
